>>> sv/mesp_pkg.sv
// Shared types and codes for the MUS event stream parser.
package mesp_pkg;

   localparam int DELAY_WIDTH     = 16;
   localparam int DELAY_OUT_WIDTH = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_IDX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_RELEASE    = 3'd0;
   localparam logic [2:0] KIND_PLAY       = 3'd1;
   localparam logic [2:0] KIND_PITCH_BEND = 3'd2;
   localparam logic [2:0] KIND_SYSTEM     = 3'd3;
   localparam logic [2:0] KIND_CONTROLLER = 3'd4;
   localparam logic [2:0] KIND_MEASURE    = 3'd5;
   localparam logic [2:0] KIND_FINISH     = 3'd6;
   localparam logic [2:0] KIND_UNUSED     = 3'd7;

   localparam logic [1:0] END_NONE    = 2'd0;
   localparam logic [1:0] END_RESTART = 2'd1;
   localparam logic [1:0] END_STOP    = 2'd2;

   // One parsed event, as handed from the parser to the formatter.
   typedef struct packed {
      logic [2:0]                 kind;
      logic [3:0]                 channel;
      logic [7:0]                 first_data;
      logic [7:0]                 second_data;
      logic                       has_volume;
      logic [DELAY_OUT_WIDTH-1:0] delay;
      logic [1:0]                 end_action;
   } evt_type;

endpackage

>>> sv/mesp_front.sv
// Byte parser: decodes descriptors, gathers data and delay bytes, emits parsed events.
module mesp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_stream_byte,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_loop_enabled,
   input  logic             q_full,
   output logic             q_push,
   output mesp_pkg::evt_type q_data
);
   import mesp_pkg::*;

   localparam logic [1:0] PH_DESC  = 2'd0;
   localparam logic [1:0] PH_DATA1 = 2'd1;
   localparam logic [1:0] PH_DATA2 = 2'd2;
   localparam logic [1:0] PH_DELAY = 2'd3;

   logic [1:0]             phase_ff, phase_in;
   logic [2:0]             kind_ff, kind_in;
   logic [3:0]             channel_ff, channel_in;
   logic                   last_ff, last_in;
   logic [7:0]             first_ff, first_in;
   logic [7:0]             second_ff, second_in;
   logic                   vol_ff, vol_in;
   logic [DELAY_WIDTH-1:0] acc_ff, acc_in;
   logic                   stopped_ff, stopped_in;
   logic                   loop_ff, loop_in;

   logic                   accept;
   logic                   work;
   logic                   emit;
   logic                   data_done;
   logic [7:0]             b;

   assign b         = req_stream_byte;
   assign req_ready = stopped_ff | ~q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;
   assign work      = accept & ~stopped_ff;

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      channel_in = channel_ff;
      last_in    = last_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      vol_in     = vol_ff;
      acc_in     = acc_ff;
      emit       = 1'b0;
      data_done  = 1'b0;
      unique case (phase_ff)
         PH_DESC: begin
            kind_in    = b[6:4];
            channel_in = b[3:0];
            last_in    = b[7];
            first_in   = '0;
            second_in  = '0;
            vol_in     = 1'b0;
            if (b[6:4] == KIND_MEASURE || b[6:4] == KIND_FINISH) begin
               data_done = 1'b1;
            end else begin
               phase_in = PH_DATA1;
            end
         end
         PH_DATA1: begin
            first_in = b;
            if (kind_ff == KIND_CONTROLLER || (kind_ff == KIND_PLAY && b[7])) begin
               vol_in   = (kind_ff == KIND_PLAY);
               phase_in = PH_DATA2;
            end else begin
               data_done = 1'b1;
            end
         end
         PH_DATA2: begin
            second_in = b;
            data_done = 1'b1;
         end
         PH_DELAY: begin
            acc_in = DELAY_WIDTH'({acc_ff, b[6:0]});
            if (!b[7]) begin
               emit = 1'b1;
            end
         end
         default: begin
            phase_in = PH_DESC;
         end
      endcase
      if (data_done) begin
         acc_in = '0;
         if (last_in) begin
            phase_in = PH_DELAY;
         end else begin
            emit = 1'b1;
         end
      end
      if (emit) begin
         phase_in = PH_DESC;
      end
   end

   always_comb begin
      q_data.kind        = kind_in;
      q_data.channel     = channel_in;
      q_data.first_data  = first_in;
      q_data.second_data = second_in;
      q_data.has_volume  = vol_in;
      q_data.delay       = last_in ? acc_in[DELAY_OUT_WIDTH-1:0] : '0;
      if (kind_in == KIND_FINISH) begin
         q_data.end_action = loop_ff ? END_RESTART : END_STOP;
      end else begin
         q_data.end_action = END_NONE;
      end
   end

   assign q_push     = work & emit;
   assign stopped_in = stopped_ff | (q_push & kind_in == KIND_FINISH & ~loop_ff);
   assign loop_in    = (csr_valid & csr_ready) ? csr_loop_enabled : loop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DESC;
         kind_ff    <= '0;
         channel_ff <= '0;
         last_ff    <= 1'b0;
         first_ff   <= '0;
         second_ff  <= '0;
         vol_ff     <= 1'b0;
         acc_ff     <= '0;
         stopped_ff <= 1'b0;
         loop_ff    <= 1'b0;
      end else begin
         loop_ff <= loop_in;
         if (work) begin
            phase_ff   <= phase_in;
            kind_ff    <= kind_in;
            channel_ff <= channel_in;
            last_ff    <= last_in;
            first_ff   <= first_in;
            second_ff  <= second_in;
            vol_ff     <= vol_in;
            acc_ff     <= acc_in;
            stopped_ff <= stopped_in;
         end
      end
   end

endmodule

>>> sv/mesp_queue.sv
// Short event queue between the parser and the formatter.
module mesp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mesp_pkg::evt_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output mesp_pkg::evt_type pop_data
);
   import mesp_pkg::*;

   evt_type                     entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full     = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/mesp_back.sv
// Formatter: maps a parsed event onto the result fields and holds the output word.
module mesp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mesp_pkg::evt_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic [3:0]        rsp_channel,
   output logic [6:0]        rsp_note_key,
   output logic              rsp_has_volume,
   output logic [6:0]        rsp_note_volume,
   output logic [6:0]        rsp_controller_number,
   output logic [7:0]        rsp_event_value,
   output logic [15:0]       rsp_delay_ticks,
   output logic [1:0]        rsp_song_end_action
);
   import mesp_pkg::*;

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  channel_ff, channel_in;
   logic [6:0]  key_ff, key_in;
   logic        has_vol_ff, has_vol_in;
   logic [6:0]  vol_ff, vol_in;
   logic [6:0]  ctrl_ff, ctrl_in;
   logic [7:0]  value_ff, value_in;
   logic [15:0] delay_ff, delay_in;
   logic [1:0]  action_ff, action_in;

   assign q_pop = ~q_empty & (~valid_ff | rsp_ready);

   always_comb begin
      kind_in    = q_data.kind;
      channel_in = q_data.channel;
      key_in     = '0;
      has_vol_in = 1'b0;
      vol_in     = '0;
      ctrl_in    = '0;
      value_in   = '0;
      delay_in   = q_data.delay;
      action_in  = q_data.end_action;
      unique case (q_data.kind)
         KIND_RELEASE: begin
            key_in = q_data.first_data[6:0];
         end
         KIND_PLAY: begin
            key_in     = q_data.first_data[6:0];
            has_vol_in = q_data.has_volume;
            vol_in     = q_data.has_volume ? q_data.second_data[6:0] : '0;
         end
         KIND_PITCH_BEND: begin
            value_in = q_data.first_data;
         end
         KIND_SYSTEM: begin
            ctrl_in = q_data.first_data[6:0];
         end
         KIND_CONTROLLER: begin
            ctrl_in  = q_data.first_data[6:0];
            value_in = {1'b0, q_data.second_data[6:0]};
         end
         KIND_MEASURE, KIND_FINISH, KIND_UNUSED: begin
         end
      endcase
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff    <= kind_in;
         channel_ff <= channel_in;
         key_ff     <= key_in;
         has_vol_ff <= has_vol_in;
         vol_ff     <= vol_in;
         ctrl_ff    <= ctrl_in;
         value_ff   <= value_in;
         delay_ff   <= delay_in;
         action_ff  <= action_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_event_kind        = kind_ff;
   assign rsp_channel           = channel_ff;
   assign rsp_note_key          = key_ff;
   assign rsp_has_volume        = has_vol_ff;
   assign rsp_note_volume       = vol_ff;
   assign rsp_controller_number = ctrl_ff;
   assign rsp_event_value       = value_ff;
   assign rsp_delay_ticks       = delay_ff;
   assign rsp_song_end_action   = action_ff;

endmodule

>>> sv/mus_event_stream_parser.sv
// An event's final byte reaches the result word through the event queue and the output
// register: the parser pushes into the queue at the accepting edge, and the formatter loads
// the output register when it pops the entry, which waits while a held word is not taken.
// Throughput: one stream byte per cycle; the parser only stalls when the 2-entry queue is full.
// After a finish event that reports stop, bytes are taken and dropped until reset.
// Synchronous reset clears the parse state, the queue, the output valid and loop_enabled.
module mus_event_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_loop_enabled,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [6:0]  rsp_note_key,
   output logic        rsp_has_volume,
   output logic [6:0]  rsp_note_volume,
   output logic [6:0]  rsp_controller_number,
   output logic [7:0]  rsp_event_value,
   output logic [15:0] rsp_delay_ticks,
   output logic [1:0]  rsp_song_end_action
);
   import mesp_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   evt_type q_in;
   evt_type q_out;

   mesp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_loop_enabled (csr_loop_enabled),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   mesp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   mesp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_data                (q_out),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_channel           (rsp_channel),
      .rsp_note_key          (rsp_note_key),
      .rsp_has_volume        (rsp_has_volume),
      .rsp_note_volume       (rsp_note_volume),
      .rsp_controller_number (rsp_controller_number),
      .rsp_event_value       (rsp_event_value),
      .rsp_delay_ticks       (rsp_delay_ticks),
      .rsp_song_end_action   (rsp_song_end_action)
   );

endmodule

>>> tb/testbench.sv
// Testbench for mus_event_stream_parser: byte stream in, decoded event words out, with prediction.
module testbench;
   import mesp_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef enum logic [1:0] {ST_DESC, ST_FIRST, ST_SECOND, ST_DELAY} parse_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  note_key;
      logic        has_volume;
      logic [6:0]  note_volume;
      logic [6:0]  controller_number;
      logic [7:0]  value;
      logic [15:0] delay_ticks;
      logic [1:0]  end_action;
   } decoded_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_stream_byte = 8'h00;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_loop_enabled = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_note_key;
   logic        rsp_has_volume;
   logic [6:0]  rsp_note_volume;
   logic [6:0]  rsp_controller_number;
   logic [7:0]  rsp_event_value;
   logic [15:0] rsp_delay_ticks;
   logic [1:0]  rsp_song_end_action;

   // predicted parser state
   parse_state_type        parse_state = ST_DESC;
   logic [2:0]             held_kind = '0;
   logic [3:0]             held_channel = '0;
   logic                   held_last = 1'b0;
   logic [7:0]             held_first = '0;
   logic [7:0]             held_second = '0;
   logic                   held_vol_flag = 1'b0;
   logic [DELAY_WIDTH-1:0] delay_acc = '0;
   logic                   song_stopped = 1'b0;
   logic                   loop_enabled = 1'b0;

   decoded_word_type expected_words[$];
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  bytes_sent = 0;
   int  rsp_hold_cycles = 0;
   bit  steady_traffic = 1'b0;

   mus_event_stream_parser dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_stream_byte       (req_stream_byte),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_loop_enabled      (csr_loop_enabled),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_channel           (rsp_channel),
      .rsp_note_key          (rsp_note_key),
      .rsp_has_volume        (rsp_has_volume),
      .rsp_note_volume       (rsp_note_volume),
      .rsp_controller_number (rsp_controller_number),
      .rsp_event_value       (rsp_event_value),
      .rsp_delay_ticks       (rsp_delay_ticks),
      .rsp_song_end_action   (rsp_song_end_action)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void emit_word();
      decoded_word_type w;
      w = '0;
      w.kind    = held_kind;
      w.channel = held_channel;
      case (held_kind)
         KIND_RELEASE: w.note_key = held_first[6:0];
         KIND_PLAY: begin
            w.note_key = held_first[6:0];
            if (held_vol_flag) begin
               w.has_volume  = 1'b1;
               w.note_volume = held_second[6:0];
            end
         end
         KIND_PITCH_BEND: w.value = held_first;
         KIND_SYSTEM: w.controller_number = held_first[6:0];
         KIND_CONTROLLER: begin
            w.controller_number = held_first[6:0];
            w.value = {1'b0, held_second[6:0]};
         end
         KIND_FINISH: begin
            if (loop_enabled) begin
               w.end_action = END_RESTART;
            end else begin
               w.end_action = END_STOP;
               song_stopped = 1'b1;
            end
         end
         default: ;
      endcase
      if (held_last)
         w.delay_ticks = delay_acc[15:0];
      expected_words.push_back(w);
      parse_state = ST_DESC;
   endfunction

   function automatic void close_event_data();
      delay_acc = '0;
      if (held_last)
         parse_state = ST_DELAY;
      else
         emit_word();
   endfunction

   function automatic void decode_stream_byte(input logic [7:0] b);
      if (song_stopped)
         return;
      case (parse_state)
         ST_DESC: begin
            held_kind     = b[6:4];
            held_channel  = b[3:0];
            held_last     = b[7];
            held_first    = '0;
            held_second   = '0;
            held_vol_flag = 1'b0;
            if (held_kind == KIND_MEASURE || held_kind == KIND_FINISH)
               close_event_data();
            else
               parse_state = ST_FIRST;
         end
         ST_FIRST: begin
            held_first = b;
            if (held_kind == KIND_CONTROLLER || (held_kind == KIND_PLAY && b[7])) begin
               held_vol_flag = (held_kind == KIND_PLAY);
               parse_state   = ST_SECOND;
            end else begin
               close_event_data();
            end
         end
         ST_SECOND: begin
            held_second = b;
            close_event_data();
         end
         default: begin
            // 7-bit groups shift in MSB first and wrap at the accumulator width
            delay_acc = {delay_acc[DELAY_WIDTH-8:0], b[6:0]};
            if (!b[7])
               emit_word();
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Leaves req_valid high after the byte is taken so back-to-back bytes need one assignment.
   task automatic send_byte(input logic [7:0] b);
      if (!steady_traffic)
         while ($urandom_range(99) < 23) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      decode_stream_byte(b);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_loop_enable(input logic v);
      csr_valid        <= 1'b1;
      csr_loop_enabled <= v;
      do @(posedge clock); while (!csr_ready);
      loop_enabled = v;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_event();
      logic [2:0] kind;
      logic       last;
      logic [7:0] first;
      int         groups;
      while (parse_state != ST_DESC)
         send_byte(8'h00);
      kind = 3'($urandom_range(7));
      // a stop would end the song for good, so finish only goes out while looping
      if (kind == KIND_FINISH && !loop_enabled)
         kind = KIND_MEASURE;
      last = 1'($urandom_range(1));
      send_byte({last, kind, 4'($urandom_range(15))});
      case (kind)
         KIND_MEASURE, KIND_FINISH: ;
         KIND_CONTROLLER: begin
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
         end
         KIND_PLAY: begin
            first = 8'($urandom_range(255));
            send_byte(first);
            if (first[7])
               send_byte(8'($urandom_range(255)));
         end
         default: send_byte(8'($urandom_range(255)));
      endcase
      if (last) begin
         groups = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
         for (int i = 0; i < groups; i++)
            send_byte({1'(i < groups - 1), 7'($urandom_range(127))});
      end
   endtask

   task automatic test_directed_fields();
      logic [7:0] seq[$];
      seq = '{8'h00, 8'hFF,                 // release, key bit 7 masked off
              8'h1F, 8'h00,                 // play ch 15, no volume
              8'h9A, 8'hFF, 8'hFF, 8'h00,   // play with volume, zero delay
              8'h2C, 8'hFF,                 // pitch bend, raw byte
              8'h33, 8'h80,                 // system
              8'h44, 8'h7F, 8'hFF,          // controller, value masked
              8'hD1, 8'hFF, 8'hFF, 8'h7F,   // measure end, delay wraps past 16 bits
              8'h75, 8'hAA,                 // unused kind swallows one byte
              8'hF0, 8'h55, 8'h81, 8'h00};  // unused kind with a two-group delay
      write_loop_enable(1'b0);
      foreach (seq[i])
         send_byte(seq[i]);
      drain_results();
   endtask

   task automatic test_finish_restart();
      write_loop_enable(1'b1);
      send_byte(8'h6F);
      send_byte(8'hE3);
      send_byte(8'h85);
      send_byte(8'h01);
      drain_results();
   endtask

   task automatic test_random_stream(input int n_bytes, input logic loop_on);
      int         start;
      logic [7:0] b;
      write_loop_enable(loop_on);
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 6)) begin
               b = 8'($urandom_range(255));
               if (parse_state == ST_DESC && b[6:4] == KIND_FINISH && !loop_enabled)
                  b[6:4] = KIND_MEASURE;
               send_byte(b);
            end
         end else begin
            send_random_event();
         end
         if ($urandom_range(149) == 0)
            drain_results();
      end
      while (parse_state != ST_DESC)
         send_byte(8'h00);
      drain_results();
   endtask

   task automatic test_backpressure();
      steady_traffic  = 1'b1;
      rsp_hold_cycles = 150;
      repeat (60) send_random_event();
      steady_traffic = 1'b0;
      // sender waits here until every word is out
      drain_results();
      repeat (20) send_random_event();
      while (parse_state != ST_DESC)
         send_byte(8'h00);
      drain_results();
   endtask

   task automatic test_stop_at_finish();
      write_loop_enable(1'b0);
      send_byte(8'hE9);
      send_byte(8'h81);
      send_byte(8'h7F);
      // everything after the stop is dropped
      repeat (16) send_byte(8'($urandom_range(255)));
      drain_results();
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_traffic || ($urandom_range(99) >= 23);
      end
   end

   always @(posedge clock) begin : check_words
      decoded_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word with nothing expected: kind %0d channel %0d",
                                      rsp_event_kind, rsp_channel));
         end else begin
            want = expected_words.pop_front();
            if (rsp_event_kind !== want.kind)
               report_mismatch($sformatf("event_kind got %0h want %0h", rsp_event_kind, want.kind));
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel got %0h want %0h", rsp_channel, want.channel));
            if (rsp_note_key !== want.note_key)
               report_mismatch($sformatf("note_key got %0h want %0h", rsp_note_key, want.note_key));
            if (rsp_has_volume !== want.has_volume)
               report_mismatch($sformatf("has_volume got %0h want %0h",
                                         rsp_has_volume, want.has_volume));
            if (rsp_note_volume !== want.note_volume)
               report_mismatch($sformatf("note_volume got %0h want %0h",
                                         rsp_note_volume, want.note_volume));
            if (rsp_controller_number !== want.controller_number)
               report_mismatch($sformatf("controller_number got %0h want %0h",
                                         rsp_controller_number, want.controller_number));
            if (rsp_event_value !== want.value)
               report_mismatch($sformatf("event_value got %0h want %0h",
                                         rsp_event_value, want.value));
            if (rsp_delay_ticks !== want.delay_ticks)
               report_mismatch($sformatf("delay_ticks got %0h want %0h",
                                         rsp_delay_ticks, want.delay_ticks));
            if (rsp_song_end_action !== want.end_action)
               report_mismatch($sformatf("song_end_action got %0h want %0h",
                                         rsp_song_end_action, want.end_action));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_fields();
      test_finish_restart();
      test_random_stream(600, 1'b1);
      test_random_stream(500, 1'b0);
      test_backpressure();
      test_random_stream(400, 1'b1);
      test_stop_at_finish();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/mesp_pkg.sv
sv/mesp_front.sv
sv/mesp_queue.sv
sv/mesp_back.sv
sv/mus_event_stream_parser.sv
tb/testbench.sv
